// ----- sv/pgpu_pkg.sv -----
// Package for the pairwise Gibbs pair update unit: word types, request and
// operation codes, controller/datapath command and status structs, constants.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package pgpu_pkg;

  localparam int NUM_VARS  = 64;
  localparam int IDX_W     = 6;
  localparam int CPL_AW    = 2 * IDX_W;
  localparam int POP_AW    = 7;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 40;

  localparam logic [2:0] REQ_FIELD = 3'd0;
  localparam logic [2:0] REQ_CPL   = 3'd1;
  localparam logic [2:0] REQ_POP   = 3'd2;
  localparam logic [2:0] REQ_SPIN  = 3'd3;
  localparam logic [2:0] REQ_UPD   = 3'd4;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_FIELD = 3'd1;
  localparam logic [2:0] OP_CPL   = 3'd2;
  localparam logic [2:0] OP_POP   = 3'd3;
  localparam logic [2:0] OP_SPIN  = 3'd4;
  localparam logic [2:0] OP_UPD   = 3'd5;

  localparam logic [30:0] ONE30     = 31'h4000_0000;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  localparam logic [16:0] C1_FLAT = 17'd16384;
  localparam logic [16:0] C2_FLAT = 17'd32768;
  localparam logic [16:0] C3_FLAT = 17'd49152;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [5:0]        var_a;
    logic [5:0]        var_b;
    logic signed [23:0] weight_value;
    logic              spin_value;
    logic [15:0]       uniform_draw;
  } in_word_t;

  typedef struct packed {
    logic        new_spin_a;
    logic        new_spin_b;
    logic [16:0] prob_a_on;
    logic [16:0] prob_b_on;
    logic [16:0] prob_both_on;
    logic [6:0]  active_total;
  } out_word_t;

  typedef struct packed {
    logic             capture;
    logic             wr_field;
    logic             wr_cpl;
    logic             cpl_swap;
    logic             wr_pop;
    logic             set_spin;
    logic             cab_read;
    logic             walk_issue;
    logic [IDX_W-1:0] walk_idx;
    logic             ps1;
    logic             ps2;
    logic             top_load;
    logic             e_d;
    logic             e_y;
    logic             e_t;
    logic             h_mul;
    logic             h_est;
    logic             h_fix;
    logic             e_sh;
    logic [1:0]       wsel;
    logic [2:0]       kval;
    logic             sum_load;
    logic             div_init;
    logic             div_step;
    logic [4:0]       div_bit;
    logic             div_store;
    logic [1:0]       dsel;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sum_zero;
  } sts_t;

  // floor(2^32 / k) for the Horner divisors; the estimate is low by at most one.
  function automatic logic [32:0] recip(input logic [2:0] k);
    logic [32:0] r;
    unique case (k)
      3'd1:    r = 33'h1_0000_0000;
      3'd2:    r = 33'h0_8000_0000;
      3'd3:    r = 33'd1431655765;
      3'd4:    r = 33'h0_4000_0000;
      3'd5:    r = 33'd858993459;
      3'd6:    r = 33'd715827882;
      default: r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pairwise_gibbs_pair_update_unit.sv -----
// Top level of the pairwise Gibbs pair update unit: controller, datapath and
// the result register. Depends on pgpu_pkg, pgpu_ctrl and pgpu_datapath.
//
//   channel   direction  handshake            word type
//   in_word   input      in_valid / in_ready  pgpu_pkg::in_word_t
//   out_word  output     out_valid/out_ready  pgpu_pkg::out_word_t
//
// A field, population or spin word is written once, a coupling word twice, at
// (a, b) and then at (b, a). An update walks the couplings (two reads of the
// coupling memory a cycle), forms the sums and the maximum, runs the four weights
// through the one shared exponent unit (six Horner steps of multiply, estimate
// and fix each) and three restoring divisions of 17 quotient bits, skipped when
// every weight underflows to zero, then commits. Reset is synchronous and clears
// the spins, the active count and all control state; the field, coupling and
// population memories are not cleared. One word is worked on at a time; a result
// waits in the output register while the next word is taken; an update stalls
// at its commit only while that register is full and not being drained.
`default_nettype none

module pairwise_gibbs_pair_update_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pgpu_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pgpu_pkg::out_word_t      out_word
);

  pgpu_pkg::cmd_t      cmd;
  pgpu_pkg::sts_t      sts;
  pgpu_pkg::out_word_t result;
  logic                out_free;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid || out_ready;

  pgpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgpu_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_word),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

  // Output register: loaded when an update commits, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_word <= result;
  end

endmodule

`default_nettype wire

// ----- sv/pgpu_ctrl.sv -----
// Controller state machine of the pairwise Gibbs pair update unit.
// Uses pgpu_pkg for command and status structs; drives pgpu_datapath.
`default_nettype none

module pgpu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_free,
  input  wire pgpu_pkg::sts_t sts,
  output pgpu_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CMD    = 5'd1;
  localparam logic [4:0] S_CPL2   = 5'd2;
  localparam logic [4:0] S_WALK   = 5'd3;
  localparam logic [4:0] S_WEND   = 5'd4;
  localparam logic [4:0] S_PS1    = 5'd5;
  localparam logic [4:0] S_PS2    = 5'd6;
  localparam logic [4:0] S_TOP    = 5'd7;
  localparam logic [4:0] S_ED     = 5'd8;
  localparam logic [4:0] S_EY     = 5'd9;
  localparam logic [4:0] S_ET     = 5'd10;
  localparam logic [4:0] S_HMUL   = 5'd11;
  localparam logic [4:0] S_HEST   = 5'd12;
  localparam logic [4:0] S_HFIX   = 5'd13;
  localparam logic [4:0] S_ESH    = 5'd14;
  localparam logic [4:0] S_SUM    = 5'd15;
  localparam logic [4:0] S_DINIT  = 5'd16;
  localparam logic [4:0] S_DSTEP  = 5'd17;
  localparam logic [4:0] S_DSTORE = 5'd18;
  localparam logic [4:0] S_FINAL  = 5'd19;

  logic [4:0]                 state, state_next;
  logic [pgpu_pkg::IDX_W-1:0] m;
  logic [1:0]                 wsel;
  logic [2:0]                 k;
  logic [1:0]                 dsel;
  logic [4:0]                 dbit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.walk_idx = m;
    cmd.wsel     = wsel;
    cmd.kval     = k;
    cmd.dsel     = dsel;
    cmd.div_bit  = dbit;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_CMD;
      end
      S_CMD: begin
        state_next = S_IDLE;
        unique case (sts.op)
          pgpu_pkg::OP_FIELD: cmd.wr_field = 1'b1;
          pgpu_pkg::OP_CPL: begin
            cmd.wr_cpl = 1'b1;
            state_next = S_CPL2;
          end
          pgpu_pkg::OP_POP:  cmd.wr_pop = 1'b1;
          pgpu_pkg::OP_SPIN: cmd.set_spin = 1'b1;
          pgpu_pkg::OP_UPD: begin
            cmd.cab_read = 1'b1;
            state_next   = S_WALK;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CPL2: begin
        cmd.wr_cpl   = 1'b1;
        cmd.cpl_swap = 1'b1;
        state_next   = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        if (m == pgpu_pkg::IDX_W'(pgpu_pkg::NUM_VARS - 1)) state_next = S_WEND;
      end
      S_WEND: state_next = S_PS1;
      S_PS1: begin
        cmd.ps1    = 1'b1;
        state_next = S_PS2;
      end
      S_PS2: begin
        cmd.ps2    = 1'b1;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd.top_load = 1'b1;
        state_next   = S_ED;
      end
      S_ED: begin
        cmd.e_d    = 1'b1;
        state_next = S_EY;
      end
      S_EY: begin
        cmd.e_y    = 1'b1;
        state_next = S_ET;
      end
      S_ET: begin
        cmd.e_t    = 1'b1;
        state_next = S_HMUL;
      end
      S_HMUL: begin
        cmd.h_mul  = 1'b1;
        state_next = S_HEST;
      end
      S_HEST: begin
        cmd.h_est  = 1'b1;
        state_next = S_HFIX;
      end
      S_HFIX: begin
        cmd.h_fix  = 1'b1;
        state_next = (k == 3'd1) ? S_ESH : S_HMUL;
      end
      S_ESH: begin
        cmd.e_sh   = 1'b1;
        state_next = (wsel == 2'd3) ? S_SUM : S_ED;
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = sts.sum_zero ? S_FINAL : S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (dbit == 5'd0) state_next = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        state_next    = (dsel == 2'd2) ? S_FINAL : S_DINIT;
      end
      S_FINAL: begin
        cmd.commit = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m     <= '0;
      wsel  <= '0;
      k     <= 3'd6;
      dsel  <= '0;
      dbit  <= 5'd16;
    end else begin
      state <= state_next;
      if (state == S_CMD) m <= '0;
      else if (state == S_WALK) m <= m + 1'b1;
      if (state == S_TOP) wsel <= '0;
      else if (state == S_ESH) wsel <= wsel + 1'b1;
      if (state == S_ET) k <= 3'd6;
      else if (state == S_HFIX) k <= k - 1'b1;
      if (state == S_SUM) dsel <= '0;
      else if (state == S_DSTORE) dsel <= dsel + 1'b1;
      if (state == S_DINIT) dbit <= 5'd16;
      else if (state == S_DSTEP) dbit <= dbit - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pgpu_datapath.sv -----
// Datapath of the pairwise Gibbs pair update unit: stores, coupling walk,
// exponent unit, normalizing divider and the final draw.
// Uses pgpu_pkg; steered by pgpu_ctrl through cmd_t.
`default_nettype none

module pgpu_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pgpu_pkg::in_word_t in_word,
  input  wire pgpu_pkg::cmd_t     cmd,
  output pgpu_pkg::sts_t          sts,
  output pgpu_pkg::out_word_t     result
);

  localparam int W = pgpu_pkg::SUM_W;

  pgpu_pkg::in_word_t req;
  logic [5:0] a, b;
  logic       a_ok, b_ok;
  logic [pgpu_pkg::POP_AW-1:0] pi;

  logic [pgpu_pkg::NUM_VARS-1:0] spins;
  logic [pgpu_pkg::CNT_W-1:0]    count, rest;

  logic signed [23:0] field_mem [0:pgpu_pkg::NUM_VARS-1];
  logic signed [23:0] cpl_mem   [0:(1 << pgpu_pkg::CPL_AW)-1];
  logic signed [23:0] pop_mem   [0:pgpu_pkg::NUM_VARS];
  logic signed [23:0] fa_q, fb_q, c0_q, c1_q, pop_q;
  logic [pgpu_pkg::CPL_AW-1:0] cw_addr, c0_addr, c1_addr;
  logic [pgpu_pkg::POP_AW-1:0] pop_raddr;

  logic       mask_d, cab_cap_d, pop_cap_d;
  logic [1:0] pop_idx_d;
  logic signed [31:0] sa, sb;
  logic signed [23:0] cab;
  logic signed [23:0] pop_r [0:2];

  logic signed [W-1:0] fsa, fsb, top;
  logic signed [W-1:0] p [0:3];
  logic signed [W-1:0] d;

  logic        dz, zflag;
  logic [19:0] dsat;
  logic [36:0] ymul;
  logic [24:0] y;
  logic [45:0] tmul;
  logic [29:0] t;
  logic [30:0] acc;
  logic [60:0] hp;
  logic [29:0] q;
  logic [62:0] ep;
  logic [29:0] est;
  logic [32:0] ek, rem;
  logic [29:0] quot;
  logic [30:0] w [0:3];

  logic [32:0] s;
  logic [32:0] x [0:2];
  logic        szero;
  logic [49:0] num, cand;
  logic [16:0] qacc;
  logic [16:0] c [0:2];

  logic [16:0] c1, c2, c3, r;
  logic        na, nb;

  assign a    = req.var_a;
  assign b    = req.var_b;
  assign a_ok = {1'b0, a} < 7'(pgpu_pkg::NUM_VARS);
  assign b_ok = {1'b0, b} < 7'(pgpu_pkg::NUM_VARS);
  assign pi   = {b[0], a};
  assign rest = count - pgpu_pkg::CNT_W'(spins[a]) - pgpu_pkg::CNT_W'(spins[b]);

  always_ff @(posedge clk) begin
    if (cmd.capture) req <= in_word;
  end

  always_comb begin
    sts.sum_zero = ((w[0] | w[1] | w[2] | w[3]) == '0);
    unique case (req.req_type)
      pgpu_pkg::REQ_FIELD: sts.op = a_ok ? pgpu_pkg::OP_FIELD : pgpu_pkg::OP_NONE;
      pgpu_pkg::REQ_CPL:   sts.op = (a_ok && b_ok) ? pgpu_pkg::OP_CPL : pgpu_pkg::OP_NONE;
      pgpu_pkg::REQ_POP:   sts.op = (pi <= 7'(pgpu_pkg::NUM_VARS)) ? pgpu_pkg::OP_POP
                                                                   : pgpu_pkg::OP_NONE;
      pgpu_pkg::REQ_SPIN:  sts.op = a_ok ? pgpu_pkg::OP_SPIN : pgpu_pkg::OP_NONE;
      pgpu_pkg::REQ_UPD:   sts.op = (a_ok && b_ok && a != b) ? pgpu_pkg::OP_UPD
                                                             : pgpu_pkg::OP_NONE;
      default:             sts.op = pgpu_pkg::OP_NONE;
    endcase
  end

  // Spins and the active count.
  always_ff @(posedge clk) begin
    if (rst) begin
      spins <= '0;
      count <= '0;
    end else if (cmd.set_spin) begin
      spins[a] <= req.spin_value;
      if (spins[a] && !req.spin_value) count <= count - 1'b1;
      else if (!spins[a] && req.spin_value) count <= count + 1'b1;
    end else if (cmd.commit) begin
      spins[a] <= na;
      spins[b] <= nb;
      count    <= rest + pgpu_pkg::CNT_W'(na) + pgpu_pkg::CNT_W'(nb);
    end
  end

  // Stores.
  assign cw_addr   = cmd.cpl_swap ? {b, a} : {a, b};
  assign c0_addr   = cmd.walk_issue ? {a, cmd.walk_idx} : {a, b};
  assign c1_addr   = {b, cmd.walk_idx};
  assign pop_raddr = rest + pgpu_pkg::POP_AW'(cmd.walk_idx[1:0]);

  always_ff @(posedge clk) begin
    if (cmd.wr_field) field_mem[a] <= req.weight_value;
    fa_q <= field_mem[a];
    fb_q <= field_mem[b];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_cpl) cpl_mem[cw_addr] <= req.weight_value;
    c0_q <= cpl_mem[c0_addr];
    c1_q <= cpl_mem[c1_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pop) pop_mem[pi] <= req.weight_value;
    pop_q <= pop_mem[pop_raddr];
  end

  // Coupling walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_d    <= 1'b0;
      cab_cap_d <= 1'b0;
      pop_cap_d <= 1'b0;
      pop_idx_d <= '0;
    end else begin
      mask_d    <= cmd.walk_issue && cmd.walk_idx != a && cmd.walk_idx != b
                   && spins[cmd.walk_idx];
      cab_cap_d <= cmd.cab_read;
      pop_cap_d <= cmd.walk_issue && cmd.walk_idx < 6'd3;
      pop_idx_d <= cmd.walk_idx[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cab_read) begin
      sa <= '0;
      sb <= '0;
    end else if (mask_d) begin
      sa <= sa + 32'(c0_q);
      sb <= sb + 32'(c1_q);
    end
    if (cab_cap_d) cab <= c0_q;
    if (pop_cap_d) pop_r[pop_idx_d] <= pop_q;
  end

  function automatic logic signed [W-1:0] top_pick(input logic signed [W-1:0] u,
                                                   input logic signed [W-1:0] v,
                                                   input logic signed [W-1:0] z);
    logic signed [W-1:0] mx;
    mx = '0;
    if (u > mx) mx = u;
    if (v > mx) mx = v;
    if (z > mx) mx = z;
    return mx;
  endfunction

  // Log weights: index 0 a on, 1 both on, 2 b on, 3 both off.
  always_ff @(posedge clk) begin
    if (cmd.ps1) begin
      fsa <= W'(fa_q) + W'(sa);
      fsb <= W'(fb_q) + W'(sb);
    end
    if (cmd.ps2) begin
      p[0] <= fsa + W'(pop_r[1]);
      p[1] <= fsa + fsb + W'(cab) + W'(pop_r[2]);
      p[2] <= fsb + W'(pop_r[1]);
      p[3] <= W'(pop_r[0]);
    end
    if (cmd.top_load) begin
      if (p[0] > top_pick(p[1], p[2], p[3])) top <= p[0];
      else top <= top_pick(p[1], p[2], p[3]);
    end
  end

  // Exponent unit, shared by the four weights.
  assign d    = top - p[cmd.wsel];
  assign ymul = 37'(dsat) * 37'(pgpu_pkg::LOG2E_Q16);
  assign tmul = 46'(y[15:0]) * 46'(pgpu_pkg::LN2_Q30);
  assign hp   = 61'(t) * 61'(acc);
  assign ep   = 63'(q) * 63'(pgpu_pkg::recip(cmd.kval));
  assign ek   = 33'(est) * 33'(cmd.kval);
  assign rem  = 33'(q) - ek;
  assign quot = (rem >= 33'(cmd.kval)) ? est + 1'b1 : est;

  always_ff @(posedge clk) begin
    if (cmd.e_d) begin
      dz   <= |d[W-1:20];
      dsat <= d[19:0];
    end
    if (cmd.e_y) y <= ymul[36:12];
    if (cmd.e_t) begin
      zflag <= dz || (y[24:16] >= 9'd31);
      t     <= tmul[45:16];
      acc   <= pgpu_pkg::ONE30;
    end
    if (cmd.h_mul) q <= hp[59:30];
    if (cmd.h_est) est <= ep[61:32];
    if (cmd.h_fix) acc <= pgpu_pkg::ONE30 - 31'(quot);
    if (cmd.e_sh) w[cmd.wsel] <= zflag ? '0 : (acc >> y[20:16]);
  end

  // Normalization: restoring division, one quotient bit a cycle.
  assign cand = 50'(s) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      s     <= 33'(w[0]) + 33'(w[1]) + 33'(w[2]) + 33'(w[3]);
      x[0]  <= 33'(w[0]);
      x[1]  <= 33'(w[0]) + 33'(w[1]);
      x[2]  <= 33'(w[0]) + 33'(w[1]) + 33'(w[2]);
      szero <= sts.sum_zero;
    end
    if (cmd.div_init) begin
      num  <= 50'({x[cmd.dsel], 16'h0000}) + 50'(s[32:1]);
      qacc <= '0;
    end
    if (cmd.div_step && num >= cand) begin
      num                <= num - cand;
      qacc[cmd.div_bit]  <= 1'b1;
    end
    if (cmd.div_store) c[cmd.dsel] <= qacc;
  end

  // Draw.
  assign c1 = szero ? pgpu_pkg::C1_FLAT : c[0];
  assign c2 = szero ? pgpu_pkg::C2_FLAT : c[1];
  assign c3 = szero ? pgpu_pkg::C3_FLAT : c[2];
  assign r  = 17'(req.uniform_draw) + 17'd1;
  assign na = (r <= c2);
  assign nb = (c1 <= r) && (r <= c3);

  always_comb begin
    result.new_spin_a   = na;
    result.new_spin_b   = nb;
    result.prob_a_on    = c2;
    result.prob_b_on    = c3 - c1;
    result.prob_both_on = c2 - c1;
    result.active_total = rest + pgpu_pkg::CNT_W'(na) + pgpu_pkg::CNT_W'(nb);
  end

endmodule

`default_nettype wire
